// ===== rtl/rtps_pkg.sv =====
// ----------------------------------------------------------------------------
// rtps_pkg: shared types and constants of the run table predecessor search
// Sizes, opcodes, status codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rtps_pkg;

   // table geometry
   localparam int MAX_RUNS = 1024;
   localparam int IDX_W    = $clog2(MAX_RUNS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int POS_W    = 32;
   localparam int CHAR_W   = 8;
   localparam int OP_W     = 2;
   localparam int ST_W     = 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_BELOW = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

   // read address source
   typedef enum logic [1:0] {
      RD_IDX  = 2'd0,
      RD_ZERO = 2'd1,
      RD_MID  = 2'd2,
      RD_LO   = 2'd3
   } rd_sel_type;

   // which result to load
   typedef enum logic [2:0] {
      RES_NONE  = 3'd0,
      RES_EMPTY = 3'd1,
      RES_RANGE = 3'd2,
      RES_BELOW = 3'd3,
      RES_ECHO  = 3'd4,
      RES_ENTRY = 3'd5
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mem_write;
      logic        map_write;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        load_key_rd;
      logic        search_init;
      logic        search_step;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            out_of_range;
      logic            below;
      logic            more;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/rtps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtps_ctrl: sequencing state machine
// Steps one transaction through decode, target read (resolve), base read,
// search probes, final fetch and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module rtps_ctrl
   import rtps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output logic               rsp_valid,
   output dp_cmd_type         cmd,
   input  wire dp_status_type sts
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_TARGET  = 8'b0000_0100,
      S_BASE    = 8'b0000_1000,
      S_PROBE   = 8'b0001_0000,
      S_FOUND   = 8'b0010_0000,
      S_FETCH   = 8'b0100_0000,
      S_RESPOND = 8'b1000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = RD_IDX;
      cmd.res_sel     = RES_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == OP_NONE) begin
               state_in = S_IDLE;
            end else if (sts.empty) begin
               cmd.res_sel = RES_EMPTY;
               state_in    = S_RESPOND;
            end else if (sts.op == OP_LOOKUP) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ZERO;
               state_in   = S_BASE;
            end else if (sts.out_of_range) begin
               cmd.res_sel = RES_RANGE;
               state_in    = S_RESPOND;
            end else if (sts.op == OP_WRITE) begin
               cmd.mem_write = 1'b1;
               cmd.res_sel   = RES_ECHO;
               state_in      = S_RESPOND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_TARGET;
            end
         end
         S_TARGET: begin
            cmd.load_key_rd = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RD_ZERO;
            state_in        = S_BASE;
         end
         S_BASE: begin
            cmd.search_init = 1'b1;
            if (sts.op == OP_LOOKUP && sts.below) begin
               cmd.res_sel = RES_BELOW;
               state_in    = S_RESPOND;
            end else if (sts.more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
               state_in   = S_PROBE;
            end else begin
               state_in = S_FOUND;
            end
         end
         S_PROBE: begin
            cmd.search_step = 1'b1;
            if (sts.more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
            end else begin
               state_in = S_FOUND;
            end
         end
         S_FOUND: begin
            cmd.rd_en = 1'b1;
            if (sts.op == OP_LOOKUP) begin
               cmd.rd_sel = RD_LO;
            end else begin
               cmd.rd_sel    = RD_IDX;
               cmd.map_write = 1'b1;
            end
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.res_sel = RES_ENTRY;
            state_in    = S_RESPOND;
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESPOND);

endmodule

`default_nettype wire

// ===== rtl/rtps_dp.sv =====
// ----------------------------------------------------------------------------
// rtps_dp: run table datapath
// Run memories, run count register, search bounds and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtps_dp
   import rtps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_data,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [IDX_W-1:0]  req_run_index,
   input  wire logic [CHAR_W-1:0] req_run_char,
   input  wire logic [POS_W-1:0]  req_input_start,
   input  wire logic [POS_W-1:0]  req_output_start,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire dp_cmd_type        cmd,
   output dp_status_type          sts,
   output logic [IDX_W-1:0]       rsp_found_index,
   output logic [CHAR_W-1:0]      rsp_found_char,
   output logic [POS_W-1:0]       rsp_found_input_start,
   output logic [POS_W-1:0]       rsp_found_output_start,
   output logic [IDX_W-1:0]       rsp_mapping_index,
   output logic [ST_W-1:0]        rsp_status
);

   // run memories
   logic [CHAR_W-1:0] char_mem [MAX_RUNS];
   logic [POS_W-1:0]  is_mem   [MAX_RUNS];
   logic [POS_W-1:0]  os_mem   [MAX_RUNS];
   logic [IDX_W-1:0]  map_mem  [MAX_RUNS];

   logic [CNT_W-1:0]  count_ff;
   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [POS_W-1:0]  is_ff;
   logic [POS_W-1:0]  os_ff;
   logic [POS_W-1:0]  key_ff;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic              below_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic [CHAR_W-1:0] rd_char_ff;
   logic [POS_W-1:0]  rd_is_ff;
   logic [POS_W-1:0]  rd_os_ff;
   logic [IDX_W-1:0]  rd_map_ff;
   logic [CNT_W-1:0]  count_m1;
   logic [IDX_W:0]    bound_sum;
   logic [IDX_W-1:0]  mid;
   logic              key_below;

   // run count, clamped to the table size
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= (csr_data > CNT_W'(MAX_RUNS)) ? CNT_W'(MAX_RUNS) : csr_data;
      end
   end

   // request capture and search key
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         idx_ff  <= req_run_index;
         char_ff <= req_run_char;
         is_ff   <= req_input_start;
         os_ff   <= req_output_start;
      end
      if (cmd.capture) begin
         key_ff <= req_position;
      end else if (cmd.load_key_rd) begin
         key_ff <= rd_os_ff;
      end
   end

   assign count_m1  = count_ff - CNT_W'(1);
   assign key_below = (key_ff < rd_is_ff);

   // search bounds
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = count_m1[IDX_W-1:0];
      end else if (cmd.search_step) begin
         if (rd_is_ff <= key_ff) begin
            lo_in = rd_addr_ff;
         end else begin
            hi_in = rd_addr_ff - IDX_W'(1);
         end
      end
   end

   assign bound_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid       = bound_sum[IDX_W:1] + IDX_W'(1);

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.search_init) begin
         below_ff <= key_below;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff;
         RD_ZERO: rd_addr = '0;
         RD_MID:  rd_addr = mid;
         RD_LO:   rd_addr = lo_ff;
         default: rd_addr = idx_ff;
      endcase
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         char_mem[idx_ff] <= char_ff;
         is_mem[idx_ff]   <= is_ff;
         os_mem[idx_ff]   <= os_ff;
      end
      if (cmd.mem_write || cmd.map_write) begin
         map_mem[idx_ff] <= cmd.map_write ? lo_ff : '0;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
         rd_char_ff <= char_mem[rd_addr];
         rd_is_ff   <= is_mem[rd_addr];
         rd_os_ff   <= os_mem[rd_addr];
         rd_map_ff  <= map_mem[rd_addr];
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      case (cmd.res_sel)
         RES_EMPTY, RES_RANGE, RES_BELOW: begin
            rsp_found_index        <= '0;
            rsp_found_char         <= '0;
            rsp_found_input_start  <= '0;
            rsp_found_output_start <= '0;
            rsp_mapping_index      <= '0;
            rsp_status             <= (cmd.res_sel == RES_EMPTY) ? ST_EMPTY :
                                      (cmd.res_sel == RES_RANGE) ? ST_RANGE : ST_BELOW;
         end
         RES_ECHO: begin
            rsp_found_index        <= idx_ff;
            rsp_found_char         <= char_ff;
            rsp_found_input_start  <= is_ff;
            rsp_found_output_start <= os_ff;
            rsp_mapping_index      <= '0;
            rsp_status             <= ST_OK;
         end
         RES_ENTRY: begin
            rsp_found_index        <= (op_ff == OP_LOOKUP) ? lo_ff : idx_ff;
            rsp_found_char         <= rd_char_ff;
            rsp_found_input_start  <= rd_is_ff;
            rsp_found_output_start <= rd_os_ff;
            rsp_mapping_index      <= (op_ff == OP_LOOKUP) ? rd_map_ff : lo_ff;
            rsp_status             <= (op_ff == OP_RESOLVE && below_ff) ? ST_BELOW : ST_OK;
         end
         default: begin
         end
      endcase
   end

   assign sts.op           = op_ff;
   assign sts.empty        = (count_ff == '0);
   assign sts.out_of_range = ({1'b0, idx_ff} >= count_ff);
   assign sts.below        = key_below;
   assign sts.more         = (hi_in > lo_in);

endmodule

`default_nettype wire

// ===== rtl/run_table_predecessor_search.sv =====
// ----------------------------------------------------------------------------
// run_table_predecessor_search: run table with predecessor search
// Top level joining the sequencing controller and the run table datapath.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low; each
// transaction except opcode 3 gives exactly one result, shown for a single
// cycle with rsp_valid high, and the receiver cannot hold it off. A write or
// an error or empty-table answer goes from decode straight to the result; a
// lookup reads the base entry and, unless the key is below it, probes and
// fetches the found entry: one probe per cycle, bounded by the compare on the
// registered read of the input start memory feeding the next probe address.
// Opcode 3 returns to idle from decode and gives nothing. run_count is written
// through the csr port, which is always ready; write it only while busy is
// low. Run entries hold whatever was last written and are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module run_table_predecessor_search
   import rtps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // input transaction
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [IDX_W-1:0]  req_run_index,
   input  wire logic [CHAR_W-1:0] req_run_char,
   input  wire logic [POS_W-1:0]  req_input_start,
   input  wire logic [POS_W-1:0]  req_output_start,
   input  wire logic [POS_W-1:0]  req_position,
   // result, one-cycle strobe
   output logic                   rsp_valid,
   output logic [IDX_W-1:0]       rsp_found_index,
   output logic [CHAR_W-1:0]      rsp_found_char,
   output logic [POS_W-1:0]       rsp_found_input_start,
   output logic [POS_W-1:0]       rsp_found_output_start,
   output logic [IDX_W-1:0]       rsp_mapping_index,
   output logic [ST_W-1:0]        rsp_status,
   // run count register
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CNT_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   // register write is a single flop load, never stalled
   assign csr_ready = 1'b1;

   rtps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memories, bounds registers and result registers
   rtps_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_valid & csr_ready),
      .csr_data               (csr_data),
      .req_opcode             (req_opcode),
      .req_run_index          (req_run_index),
      .req_run_char           (req_run_char),
      .req_input_start        (req_input_start),
      .req_output_start       (req_output_start),
      .req_position           (req_position),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_found_index        (rsp_found_index),
      .rsp_found_char         (rsp_found_char),
      .rsp_found_input_start  (rsp_found_input_start),
      .rsp_found_output_start (rsp_found_output_start),
      .rsp_mapping_index      (rsp_mapping_index),
      .rsp_status             (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/rtps_checker.sv =====
// ----------------------------------------------------------------------------
// rtps_checker: port-level checks of the run table predecessor search
// Watches the transaction handshake and result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rtps_checker
   import rtps_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic [IDX_W-1:0]  rsp_found_index,
   input wire logic [CHAR_W-1:0] rsp_found_char,
   input wire logic [ST_W-1:0]   rsp_status
);

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // a result only comes out of a transaction in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

   // one strobe per result, and the block is free right after
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   // an empty-table answer carries no run
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_found_index == '0 && rsp_found_char == '0)
      else $error("empty-table result with run fields");

endmodule

bind run_table_predecessor_search rtps_checker u_rtps_checker (.*);

`default_nettype wire
